>>> hw/rtl/im2col_pkg.sv
// ----------------------------------------------------------------------------
// im2col_pkg
// Shared types, register codes and helper functions of the im2col patch
// address generator.
// ----------------------------------------------------------------------------
package im2col_pkg;

	// limits of the supported tensor shapes
	localparam int MAX_BATCH      = 16;
	localparam int MAX_IMAGE_DIM  = 1024;
	localparam int MAX_KERNEL_DIM = 8;
	localparam int MAX_DEPTH      = 1024;
	localparam int MAX_STEP       = 8;

	// reciprocal precision for the small constant divides
	localparam int RECIP_SHIFT = 20;
	localparam int RECIP_W     = RECIP_SHIFT + 1;

	// configuration register indexes, word addressed
	typedef enum logic [2:0] {
		REG_IN_HEIGHT   = 3'd0,
		REG_IN_WIDTH    = 3'd1,
		REG_IN_DEPTH    = 3'd2,
		REG_KERNEL_ROWS = 3'd3,
		REG_KERNEL_COLS = 3'd4,
		REG_STEP_ROWS   = 3'd5,
		REG_STEP_COLS   = 3'd6,
		REG_PAD_SAME    = 3'd7
	} cfg_reg_t;

	// request beat
	typedef struct packed {
		logic [3:0] image_index;
		logic [9:0] out_row;
		logic [9:0] out_col;
	} patch_req_t;

	// result beat
	typedef struct packed {
		logic [33:0] elem_address;
		logic        is_padding;
		logic [2:0]  tap_row;
		logic [2:0]  tap_col;
		logic        last_tap;
	} tap_res_t;

	// zero reads as one, large values saturate at the limit
	function automatic logic [10:0] clamp_dim(input logic [10:0] v, input logic [10:0] hi);
		logic [10:0] r;
		if (v == 11'd0) begin
			r = 11'd1;
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

	// same rule for the 4-bit filter and stride registers
	function automatic logic [3:0] clamp_small(input logic [3:0] v, input logic [3:0] hi);
		logic [3:0] r;
		if (v == 4'd0) begin
			r = 4'd1;
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

	// ceil(2^RECIP_SHIFT / s) for the stride values, exact floor divide for 11-bit dividends
	function automatic logic [RECIP_W-1:0] stride_recip(input logic [3:0] s);
		logic [RECIP_W-1:0] r;
		case (s)
			4'd2:    r = RECIP_W'(524288);
			4'd3:    r = RECIP_W'(349526);
			4'd4:    r = RECIP_W'(262144);
			4'd5:    r = RECIP_W'(209716);
			4'd6:    r = RECIP_W'(174763);
			4'd7:    r = RECIP_W'(149797);
			4'd8:    r = RECIP_W'(131072);
			default: r = RECIP_W'(1048576);
		endcase
		return r;
	endfunction

endpackage

>>> hw/rtl/im2col_patch_address_generator.sv
// ----------------------------------------------------------------------------
// im2col_patch_address_generator
// Walks every filter tap of a patch request and gives the NHWC element
// address of the tap's input pixel, or a padding flag outside the image.
// ----------------------------------------------------------------------------
//
// channel   | dir | handshake                         | beat
// ----------+-----+-----------------------------------+---------------------
// request   | in  | start high, busy low at clk edge  | req (patch_req_t)
// result    | out | res_valid high for one cycle      | res (tap_res_t)
// registers | in  | apb write: psel penable pwrite    | paddr, pwdata, prdata
//
// a request makes kernel_rows * kernel_cols result beats, one per cycle; the
// tap walker issues one tap a cycle and sets that rate. the next request is
// taken in the cycle that the previous one issues its last tap, so taps of
// consecutive requests follow without a gap. the first result of a request
// passes the tap walker and every pipeline stage before it shows. reset
// clears the tap walker, the stage valid bits and loads the register
// defaults. the receiver cannot stall, so the pipeline never holds.
//
module im2col_patch_address_generator
	import im2col_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// request side
	input  logic       start,
	output logic       busy,
	input  patch_req_t req,
	// result side
	output logic       res_valid,
	output tap_res_t   res,
	// register port
	input  logic       psel,
	input  logic       penable,
	input  logic       pwrite,
	input  logic [4:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic       pready
);

	// ------------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------------
	logic [10:0] in_height_q, in_width_q, in_depth_q;
	logic [3:0]  kernel_rows_q, kernel_cols_q, step_rows_q, step_cols_q;
	logic        pad_same_q;
	logic        cfg_wr;
	cfg_reg_t    cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = cfg_reg_t'(paddr[4:2]);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_height_q   <= 11'd1;
			in_width_q    <= 11'd1;
			in_depth_q    <= 11'd1;
			kernel_rows_q <= 4'd1;
			kernel_cols_q <= 4'd1;
			step_rows_q   <= 4'd1;
			step_cols_q   <= 4'd1;
			pad_same_q    <= 1'b0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_IN_HEIGHT:   in_height_q   <= pwdata[10:0];
				REG_IN_WIDTH:    in_width_q    <= pwdata[10:0];
				REG_IN_DEPTH:    in_depth_q    <= pwdata[10:0];
				REG_KERNEL_ROWS: kernel_rows_q <= pwdata[3:0];
				REG_KERNEL_COLS: kernel_cols_q <= pwdata[3:0];
				REG_STEP_ROWS:   step_rows_q   <= pwdata[3:0];
				REG_STEP_COLS:   step_cols_q   <= pwdata[3:0];
				REG_PAD_SAME:    pad_same_q    <= pwdata[0];
				default:         pad_same_q    <= pad_same_q;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (cfg_idx)
			REG_IN_HEIGHT:   prdata = {21'd0, in_height_q};
			REG_IN_WIDTH:    prdata = {21'd0, in_width_q};
			REG_IN_DEPTH:    prdata = {21'd0, in_depth_q};
			REG_KERNEL_ROWS: prdata = {28'd0, kernel_rows_q};
			REG_KERNEL_COLS: prdata = {28'd0, kernel_cols_q};
			REG_STEP_ROWS:   prdata = {28'd0, step_rows_q};
			REG_STEP_COLS:   prdata = {28'd0, step_cols_q};
			REG_PAD_SAME:    prdata = {31'd0, pad_same_q};
			default:         prdata = 32'd0;
		endcase
	end

	// clamped values; the user keeps them stable while requests fly, unenforced
	logic [10:0] h_c, w_c, d_c;
	logic [3:0]  kr_c, kc_c, sr_c, sc_c;
	logic [2:0]  kr_m1, kc_m1;

	assign h_c   = clamp_dim(in_height_q, 11'(MAX_IMAGE_DIM));
	assign w_c   = clamp_dim(in_width_q, 11'(MAX_IMAGE_DIM));
	assign d_c   = clamp_dim(in_depth_q, 11'(MAX_DEPTH));
	assign kr_c  = clamp_small(kernel_rows_q, 4'(MAX_KERNEL_DIM));
	assign kc_c  = clamp_small(kernel_cols_q, 4'(MAX_KERNEL_DIM));
	assign sr_c  = clamp_small(step_rows_q, 4'(MAX_STEP));
	assign sc_c  = clamp_small(step_cols_q, 4'(MAX_STEP));
	assign kr_m1 = 3'(kr_c - 4'd1);
	assign kc_m1 = 3'(kc_c - 4'd1);

	// ------------------------------------------------------------------------
	// tap walker
	// ------------------------------------------------------------------------
	logic       active_q;
	logic [2:0] tr_q, tc_q;
	patch_req_t req_q;
	logic       tap_last;
	logic       walk_last;
	logic       req_accept;

	assign tap_last   = (tr_q == kr_m1) && (tc_q == kc_m1);
	assign walk_last  = active_q && tap_last;
	assign busy       = active_q && !tap_last;
	assign req_accept = start && !busy;

	// row-major tap counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			tr_q     <= 3'd0;
			tc_q     <= 3'd0;
		end else if (req_accept) begin
			active_q <= 1'b1;
			tr_q     <= 3'd0;
			tc_q     <= 3'd0;
		end else if (active_q) begin
			if (tap_last) begin
				active_q <= 1'b0;
			end else if (tc_q == kc_m1) begin
				tc_q <= 3'd0;
				tr_q <= 3'(tr_q + 3'd1);
			end else begin
				tc_q <= 3'(tc_q + 3'd1);
			end
		end
	end

	// request hold, batch index wraps at the batch limit
	always_ff @(posedge clk) begin
		if (req_accept) begin
			req_q.image_index <= 4'(req.image_index % MAX_BATCH);
			req_q.out_row     <= req.out_row;
			req_q.out_col     <= req.out_col;
		end
	end

	// ------------------------------------------------------------------------
	// stage 1: output size quotients, origin products
	// ------------------------------------------------------------------------
	logic [10:0] row_dvd, col_dvd;
	logic [31:0] row_prod, col_prod;
	logic        row_ge, col_ge;

	assign row_ge   = h_c >= {7'd0, kr_c};
	assign col_ge   = w_c >= {7'd0, kc_c};
	assign row_dvd  = pad_same_q ? 11'(h_c + {7'd0, sr_c} - 11'd1) : 11'(h_c - {7'd0, kr_c});
	assign col_dvd  = pad_same_q ? 11'(w_c + {7'd0, sc_c} - 11'd1) : 11'(w_c - {7'd0, kc_c});
	assign row_prod = 32'(row_dvd) * 32'(stride_recip(sr_c));
	assign col_prod = 32'(col_dvd) * 32'(stride_recip(sc_c));

	logic        v_s1;
	logic [3:0]  img_s1;
	logic [2:0]  tr_s1, tc_s1;
	logic        last_s1;
	logic [10:0] rq_s1, cq_s1;
	logic        rge_s1, cge_s1;
	logic [13:0] orow_s1, ocol_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= active_q;
		end
	end

	always_ff @(posedge clk) begin
		img_s1  <= req_q.image_index;
		tr_s1   <= tr_q;
		tc_s1   <= tc_q;
		last_s1 <= tap_last;
		rq_s1   <= row_prod[RECIP_SHIFT+10:RECIP_SHIFT];
		cq_s1   <= col_prod[RECIP_SHIFT+10:RECIP_SHIFT];
		rge_s1  <= row_ge;
		cge_s1  <= col_ge;
		orow_s1 <= 14'(req_q.out_row) * 14'(sr_c);
		ocol_s1 <= 14'(req_q.out_col) * 14'(sc_c);
	end

	// ------------------------------------------------------------------------
	// stage 2: output sizes and padding offsets, halved toward zero
	// ------------------------------------------------------------------------
	logic [10:0]        out_rows, out_cols;
	logic signed [15:0] num_r, num_c, adj_r, adj_c;
	logic signed [15:0] valid_bias;

	assign valid_bias = $signed({15'd0, !pad_same_q});
	assign out_rows   = pad_same_q ? rq_s1 : (rge_s1 ? 11'(rq_s1 + 11'd1) : 11'd0);
	assign out_cols   = pad_same_q ? cq_s1 : (cge_s1 ? 11'(cq_s1 + 11'd1) : 11'd0);
	assign num_r = ($signed({5'd0, out_rows}) - 16'sd1) * $signed({12'd0, sr_c})
		+ $signed({12'd0, kr_c}) - $signed({5'd0, h_c}) + valid_bias;
	assign num_c = ($signed({5'd0, out_cols}) - 16'sd1) * $signed({12'd0, sc_c})
		+ $signed({12'd0, kc_c}) - $signed({5'd0, w_c}) + valid_bias;
	assign adj_r = num_r + $signed({15'd0, num_r[15]});
	assign adj_c = num_c + $signed({15'd0, num_c[15]});

	logic               v_s2;
	logic [3:0]         img_s2;
	logic [2:0]         tr_s2, tc_s2;
	logic               last_s2;
	logic signed [11:0] top_s2, left_s2;
	logic [13:0]        orow_s2, ocol_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		img_s2  <= img_s1;
		tr_s2   <= tr_s1;
		tc_s2   <= tc_s1;
		last_s2 <= last_s1;
		top_s2  <= 12'(adj_r >>> 1);
		left_s2 <= 12'(adj_c >>> 1);
		orow_s2 <= orow_s1;
		ocol_s2 <= ocol_s1;
	end

	// ------------------------------------------------------------------------
	// stage 3: tap pixel position, bounds check, batch row base
	// ------------------------------------------------------------------------
	logic signed [15:0] y_c, x_c;
	logic               pad_c;

	assign y_c = $signed({2'd0, orow_s2}) - 16'(top_s2) + $signed({13'd0, tr_s2});
	assign x_c = $signed({2'd0, ocol_s2}) - 16'(left_s2) + $signed({13'd0, tc_s2});
	assign pad_c = (y_c < 16'sd0) || (y_c >= $signed({5'd0, h_c}))
		|| (x_c < 16'sd0) || (x_c >= $signed({5'd0, w_c}));

	logic        v_s3;
	logic [2:0]  tr_s3, tc_s3;
	logic        last_s3, pad_s3;
	logic [9:0]  y_s3, x_s3;
	logic [13:0] imgh_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		tr_s3   <= tr_s2;
		tc_s3   <= tc_s2;
		last_s3 <= last_s2;
		pad_s3  <= pad_c;
		y_s3    <= y_c[9:0];
		x_s3    <= x_c[9:0];
		imgh_s3 <= 14'(img_s2) * 14'(h_c);
	end

	// ------------------------------------------------------------------------
	// stage 4: pixel index within the batch
	// ------------------------------------------------------------------------
	logic        v_s4;
	logic [2:0]  tr_s4, tc_s4;
	logic        last_s4, pad_s4;
	logic [23:0] pix_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		tr_s4   <= tr_s3;
		tc_s4   <= tc_s3;
		last_s4 <= last_s3;
		pad_s4  <= pad_s3;
		pix_s4  <= 24'(imgh_s3 + 14'(y_s3)) * 24'(w_c) + 24'(x_s3);
	end

	// ------------------------------------------------------------------------
	// stage 5: element address, result register
	// ------------------------------------------------------------------------
	logic        v_s5;
	logic [2:0]  tr_s5, tc_s5;
	logic        last_s5, pad_s5;
	logic [33:0] addr_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		tr_s5   <= tr_s4;
		tc_s5   <= tc_s4;
		last_s5 <= last_s4;
		pad_s5  <= pad_s4;
		addr_s5 <= pad_s4 ? 34'd0 : 34'(pix_s4) * 34'(d_c);
	end

	// result beat
	assign res_valid = v_s5;
	always_comb begin
		res.elem_address = addr_s5;
		res.is_padding   = pad_s5;
		res.tap_row      = tr_s5;
		res.tap_col      = tc_s5;
		res.last_tap     = last_s5;
	end

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------

	// taps of one patch leave in consecutive cycles
	a_taps_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.last_tap |=> res_valid)
		else $error("result gap inside a patch");

	// a padding beat never carries an address
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.is_padding |-> res.elem_address == 34'd0)
		else $error("padding beat with nonzero address");

	// an accepted request starts its walk at the first tap
	a_walk_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> active_q && tr_q == 3'd0 && tc_q == 3'd0)
		else $error("tap walk did not restart on accept");

	// the final tap of a patch is the last filter position
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		walk_last |=> v_s1 && last_s1 && tr_s1 == kr_m1 && tc_s1 == kc_m1)
		else $error("last tap flag out of place");

endmodule

>>> verif/im2col_patch_address_generator_test.sv
// ----------------------------------------------------------------------------
// im2col_patch_address_generator_test
// Self-checking bench: patch requests go in through start/busy, every tap
// beat is checked field by field against a local model of the tap walk,
// under many register settings written over the apb port while idle.
// ----------------------------------------------------------------------------
module im2col_patch_address_generator_test
	import im2col_pkg::*;
();

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 12;

	// register shadow at the register widths
	typedef struct {
		logic [10:0] height;
		logic [10:0] width;
		logic [10:0] depth;
		logic [3:0]  krows;
		logic [3:0]  kcols;
		logic [3:0]  srows;
		logic [3:0]  scols;
		logic        same;
	} shape_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	patch_req_t  req = '0;
	logic        res_valid;
	tap_res_t    res;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	shape_t      shape = '{11'd1, 11'd1, 11'd1, 4'd1, 4'd1, 4'd1, 4'd1, 1'b0};
	patch_req_t  pending_patches[$];
	tap_res_t    expected_taps[$];
	int          mismatches = 0;
	int          cycle_count = 0;
	int          gap_left = 0;
	bit          gaps_on = 1'b1;
	logic        present_next;

	im2col_patch_address_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.res_valid(res_valid),
		.res(res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// zero reads as one, large values saturate
	function automatic longint fold_dim(input longint v, input longint hi);
		if (v == 0) begin
			return 1;
		end
		return (v > hi) ? hi : v;
	endfunction

	// windowed output size
	function automatic longint out_extent(input longint in_sz, input longint k,
			input longint s, input logic same);
		if (same) begin
			return (in_sz + s - 1) / s;
		end
		if (in_sz < k) begin
			return 0;
		end
		return (in_sz - k) / s + 1;
	endfunction

	// leading pad, signed divide truncates toward zero
	function automatic longint lead_pad(input longint outs, input longint s,
			input longint k, input longint in_sz, input logic same);
		return ((outs - 1) * s + k - in_sz + (same ? 0 : 1)) / 2;
	endfunction

	// work out every tap beat of one accepted patch
	task automatic predict_taps(input patch_req_t r);
		longint h, w, d, kr, kc, sr, sc;
		longint top, left, y0, x0, y, x;
		logic [63:0] addr;
		tap_res_t t;
		h = fold_dim(shape.height, MAX_IMAGE_DIM);
		w = fold_dim(shape.width, MAX_IMAGE_DIM);
		d = fold_dim(shape.depth, MAX_DEPTH);
		kr = fold_dim(shape.krows, MAX_KERNEL_DIM);
		kc = fold_dim(shape.kcols, MAX_KERNEL_DIM);
		sr = fold_dim(shape.srows, MAX_STEP);
		sc = fold_dim(shape.scols, MAX_STEP);
		top = lead_pad(out_extent(h, kr, sr, shape.same), sr, kr, h, shape.same);
		left = lead_pad(out_extent(w, kc, sc, shape.same), sc, kc, w, shape.same);
		y0 = longint'(r.out_row) * sr - top;
		x0 = longint'(r.out_col) * sc - left;
		for (longint i = 0; i < kr; i++) begin
			for (longint j = 0; j < kc; j++) begin
				y = y0 + i;
				x = x0 + j;
				t.is_padding = (y < 0) || (y >= h) || (x < 0) || (x >= w);
				addr = '0;
				if (!t.is_padding) begin
					addr = ((longint'(r.image_index) * h + y) * w + x) * d;
				end
				t.elem_address = addr[33:0];
				t.tap_row = i[2:0];
				t.tap_col = j[2:0];
				t.last_tap = (i == kr - 1) && (j == kc - 1);
				expected_taps.push_back(t);
			end
		end
	endtask

	// request driver: presents queued patches with random idle bursts
	always @(posedge clk) begin
		if (arst_n) begin
			present_next = start;
			if (start && !busy) begin
				predict_taps(req);
				present_next = 1'b0;
			end
			if (!present_next) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_patches.size() > 0) begin
					if (gaps_on && $urandom_range(0, 3) == 0) begin
						gap_left = $urandom_range(1, 6) - 1;
					end else begin
						req <= pending_patches.pop_front();
						present_next = 1'b1;
					end
				end
			end
			start <= present_next;
		end
	end

	// result monitor
	always @(posedge clk) begin
		tap_res_t want;
		if (arst_n && res_valid) begin
			if (expected_taps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected tap beat: addr %0d pad %0b row %0d col %0d last %0b",
						res.elem_address, res.is_padding, res.tap_row, res.tap_col,
						res.last_tap);
				end
			end else begin
				want = expected_taps.pop_front();
				if (res.elem_address !== want.elem_address ||
						res.is_padding !== want.is_padding ||
						res.tap_row !== want.tap_row || res.tap_col !== want.tap_col ||
						res.last_tap !== want.last_tap) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("tap mismatch: exp addr %0d pad %0b row %0d col %0d last %0b",
							want.elem_address, want.is_padding, want.tap_row,
							want.tap_col, want.last_tap);
						$display("              got addr %0d pad %0b row %0d col %0d last %0b",
							res.elem_address, res.is_padding, res.tap_row, res.tap_col,
							res.last_tap);
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** im2col_patch_address_generator: FAILED **");
			$finish;
		end
	end

	// apb write: setup then access, done once pready is seen
	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_IN_HEIGHT:   shape.height = value[10:0];
			REG_IN_WIDTH:    shape.width = value[10:0];
			REG_IN_DEPTH:    shape.depth = value[10:0];
			REG_KERNEL_ROWS: shape.krows = value[3:0];
			REG_KERNEL_COLS: shape.kcols = value[3:0];
			REG_STEP_ROWS:   shape.srows = value[3:0];
			REG_STEP_COLS:   shape.scols = value[3:0];
			default:         shape.same = value[0];
		endcase
	endtask

	task automatic load_shape(input logic [31:0] h, input logic [31:0] w,
			input logic [31:0] d, input logic [31:0] kr, input logic [31:0] kc,
			input logic [31:0] sr, input logic [31:0] sc, input logic [31:0] same);
		write_reg(REG_IN_HEIGHT, h);
		write_reg(REG_IN_WIDTH, w);
		write_reg(REG_IN_DEPTH, d);
		write_reg(REG_KERNEL_ROWS, kr);
		write_reg(REG_KERNEL_COLS, kc);
		write_reg(REG_STEP_ROWS, sr);
		write_reg(REG_STEP_COLS, sc);
		write_reg(REG_PAD_SAME, same);
	endtask

	// sender holds off until every tap has come back, then lets the pipe empty
	// checked on the falling edge so driver updates of the rising edge have settled
	task automatic drain();
		while (pending_patches.size() > 0 || start || busy || expected_taps.size() > 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_patch(input int img, input int row, input int col);
		patch_req_t p;
		p.image_index = img[3:0];
		p.out_row = row[9:0];
		p.out_col = col[9:0];
		pending_patches.push_back(p);
	endtask

	// random size register: mostly small images, sometimes extremes
	function automatic logic [31:0] pick_dim();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 5) begin
			return $urandom_range(1, 16);
		end else if (sel < 8) begin
			return $urandom_range(1, 1024);
		end else if (sel == 8) begin
			return 1024;
		end
		return $urandom;
	endfunction

	// random filter or stride register
	function automatic logic [31:0] pick_small(input int hi);
		if ($urandom_range(0, 4) == 0) begin
			return $urandom;
		end
		return $urandom_range(1, hi);
	endfunction

	// patches mostly inside the output grid, some anywhere
	task automatic queue_random_patches(input int n);
		longint orows, ocols;
		int row, col;
		orows = out_extent(fold_dim(shape.height, MAX_IMAGE_DIM),
			fold_dim(shape.krows, MAX_KERNEL_DIM), fold_dim(shape.srows, MAX_STEP),
			shape.same);
		ocols = out_extent(fold_dim(shape.width, MAX_IMAGE_DIM),
			fold_dim(shape.kcols, MAX_KERNEL_DIM), fold_dim(shape.scols, MAX_STEP),
			shape.same);
		if (orows > 1024) orows = 1024;
		if (ocols > 1024) ocols = 1024;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) != 0 && orows > 0 && ocols > 0) begin
				row = $urandom_range(0, int'(orows) - 1);
				col = $urandom_range(0, int'(ocols) - 1);
			end else begin
				row = $urandom_range(0, 1023);
				col = $urandom_range(0, 1023);
			end
			queue_patch($urandom_range(0, 15), row, col);
		end
	endtask

	// stimulus
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset defaults: 1x1 image and filter, second patch off the grid
		queue_patch(0, 0, 0);
		queue_patch(15, 1023, 1023);
		drain();

		// valid 3x3 over a small image, last grid cell and beyond the grid
		load_shape(5, 6, 3, 3, 3, 1, 1, 0);
		queue_patch(0, 0, 0);
		queue_patch(1, 2, 3);
		queue_patch(15, 2, 3);
		queue_patch(3, 3, 0);
		drain();

		// same padding with an even filter and unequal strides
		load_shape(7, 9, 16, 4, 3, 2, 3, 1);
		queue_patch(0, 0, 0);
		queue_patch(2, 3, 2);
		queue_patch(9, 1, 1);
		drain();

		// zero registers read as one
		load_shape(0, 0, 0, 0, 0, 0, 0, 0);
		queue_patch(5, 0, 0);
		queue_patch(10, 1, 0);
		drain();

		// all ones: sizes saturate, 8x8 filter, stride 8, same padding
		load_shape('1, '1, '1, '1, '1, '1, '1, '1);
		queue_patch(15, 127, 127);
		queue_patch(0, 0, 0);
		queue_patch(15, 1023, 1023);
		queue_patch(7, 64, 100);
		drain();

		// filter larger than the image in valid mode
		load_shape(3, 2, 5, 8, 5, 8, 3, 0);
		queue_patch(0, 0, 0);
		queue_patch(4, 1, 1);
		drain();

		// largest address
		load_shape(1024, 1024, 1024, 1, 1, 1, 1, 0);
		queue_patch(15, 1023, 1023);
		queue_patch(8, 512, 0);
		drain();

		// random settings, the last one without idle bursts
		for (int phase = 0; phase < 16; phase++) begin
			load_shape(pick_dim(), pick_dim(), pick_dim(), pick_small(4), pick_small(4),
				pick_small(3), pick_small(3), $urandom_range(0, 1));
			if (phase == 15) begin
				gaps_on = 1'b0;
			end
			queue_random_patches(24);
			drain();
		end

		if (mismatches == 0) begin
			$display("** im2col_patch_address_generator: PASSED **");
		end else begin
			$display("** im2col_patch_address_generator: FAILED **");
		end
		$finish;
	end

endmodule
